>>> src/rotation_invariant_ilbp_code_macros.svh
// Assertion macros for the rotation-invariant ILBP code block checker
`ifndef ROTATION_INVARIANT_ILBP_CODE_MACROS_SVH
`define ROTATION_INVARIANT_ILBP_CODE_MACROS_SVH

// same-cycle implication, off during reset
`define RIILBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RIILBP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live during reset
`define RIILBP_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/riilbp_pkg.sv
// Types, constants and functions shared by the rotation-invariant ILBP code block
`default_nettype none

package riilbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int PIX_W      = 8;
  localparam int WIN_N      = 9;
  localparam int WIN_IDX_W  = $clog2(WIN_N);
  localparam int CODE_W     = 9;
  localparam int SUM_W      = 12;
  localparam int MEAN_RECIP = 7282;
  localparam int MEAN_SHIFT = 16;
  localparam int PROD_W     = SUM_W + 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = WIDTH_W'(3);
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = HEIGHT_W'(3);
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH_V  = WIDTH_W'(MAX_WIDTH);

  // window positions in comparison-word order, MSB first:
  // top-left, top, top-right, right, bottom-right, bottom, bottom-left, left, center
  localparam logic [WIN_IDX_W-1:0] NEIGHBOR_IDX [WIN_N] = '{
    WIN_IDX_W'(0), WIN_IDX_W'(1), WIN_IDX_W'(2), WIN_IDX_W'(5), WIN_IDX_W'(8),
    WIN_IDX_W'(7), WIN_IDX_W'(6), WIN_IDX_W'(3), WIN_IDX_W'(4)
  };

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef pix_t [WIN_N-1:0]  win_t;

  typedef struct packed {
    pix_t pixel_value;
    logic frame_start;
  } riilbp_in_t;

  typedef struct packed {
    code_t pattern_code;
    logic  frame_done;
  } riilbp_out_t;

  typedef struct packed {
    logic emit;
    logic frame_done;
  } code_ctl_t;

  function automatic sum_t window_sum(input win_t win);
    sum_t acc;
    acc = '0;
    for (int i = 0; i < WIN_N; i++) begin
      acc = acc + SUM_W'(win[i]);
    end
    return acc;
  endfunction

  function automatic code_t compare_word(input win_t win, input pix_t mean);
    code_t word;
    word = '0;
    for (int i = 0; i < WIN_N; i++) begin
      word[CODE_W-1-i] = (win[NEIGHBOR_IDX[i]] >= mean);
    end
    return word;
  endfunction

  function automatic code_t min_rotation(input code_t word);
    code_t best;
    code_t rot;
    best = '1;
    rot = word;
    for (int k = 0; k < CODE_W; k++) begin
      if (rot < best) best = rot;
      rot = {rot[CODE_W-2:0], rot[CODE_W-1]};
    end
    return best;
  endfunction

endpackage

`default_nettype wire

>>> src/riilbp_code.sv
// Window-to-code pipeline: sum, mean, comparison word, minimum rotation
`default_nettype none

module riilbp_code import riilbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        win_valid,
  output logic        win_ready,
  input  win_t        win,
  input  code_ctl_t   win_ctl,
  output logic        out_valid,
  input  logic        out_ready,
  output riilbp_out_t out_data
);

  logic        sum_valid;
  sum_t        sum_val;
  win_t        sum_win;
  code_ctl_t   sum_ctl;
  logic        mean_valid;
  pix_t        mean_val;
  win_t        mean_win;
  code_ctl_t   mean_ctl;
  logic        out_free;
  logic        mean_fire;
  logic        sum_fire;
  logic [PROD_W-1:0] mean_prod;

  assign out_free  = !out_valid || out_ready;
  assign mean_fire = mean_valid && (out_free || !mean_ctl.emit);
  assign sum_fire  = sum_valid && (!mean_valid || mean_fire);
  assign win_ready = !sum_valid || sum_fire;
  assign mean_prod = PROD_W'(sum_val) * PROD_W'(MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid  <= 1'b0;
      mean_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (win_valid && win_ready) sum_valid <= 1'b1;
      else if (sum_fire)          sum_valid <= 1'b0;
      if (sum_fire)       mean_valid <= 1'b1;
      else if (mean_fire) mean_valid <= 1'b0;
      if (mean_fire && mean_ctl.emit) out_valid <= 1'b1;
      else if (out_ready)             out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid && win_ready) begin
      sum_val <= window_sum(win);
      sum_win <= win;
      sum_ctl <= win_ctl;
    end
    if (sum_fire) begin
      mean_val <= mean_prod[MEAN_SHIFT +: PIX_W];
      mean_win <= sum_win;
      mean_ctl <= sum_ctl;
    end
    if (mean_fire && mean_ctl.emit) begin
      out_data.pattern_code <= min_rotation(compare_word(mean_win, mean_val));
      out_data.frame_done   <= mean_ctl.frame_done;
    end
  end

endmodule

`default_nettype wire

>>> src/rotation_invariant_ilbp_code.sv
// Rotation-invariant 3x3 ILBP code block: one pixel per clock in raster order, one
// code per interior pixel. Throughput is one pixel per cycle while the output side
// keeps up; each pixel does one read and one write of the two 1024 x 8 line stores
// at its column, with same-column back-to-back accesses served by forwarding. A code
// passes in turn through the read, window, sum, mean and output registers.
// Pixels in rows 0 and 1 or columns 0 and 1 give no code; frame_done marks the code
// of the last interior pixel. Line stores need no clearing after reset.
`default_nettype none

module rotation_invariant_ilbp_code import riilbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  riilbp_in_t            in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output riilbp_out_t           out_data
);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  eff_width;
  logic [HEIGHT_W-1:0] eff_height;
  logic [WIDTH_W-1:0]  last_col;
  logic [HEIGHT_W-1:0] last_row;

  logic [COL_W-1:0]    column_count;
  logic [HEIGHT_W-1:0] row_count;
  logic [COL_W-1:0]    cur_col;
  logic [HEIGHT_W-1:0] cur_row;
  logic [COL_W-1:0]    column_count_next;
  logic [HEIGHT_W-1:0] row_count_next;
  logic                row_end;
  logic                frame_end;
  logic                in_fire;

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t upper_rd;
  pix_t middle_rd;

  logic             rd_valid;
  logic [COL_W-1:0] rd_col;
  pix_t             rd_pix;
  code_ctl_t        rd_ctl;
  logic             rd_fwd;
  pix_t             fwd_top;
  pix_t             fwd_mid;
  pix_t             rd_top;
  pix_t             rd_mid;
  logic             rd_fire;

  logic      win_valid;
  logic      win_ready;
  win_t      win;
  code_ctl_t win_ctl;

  always_comb begin
    eff_width = image_width;
    if (image_width < MIN_WIDTH)   eff_width = MIN_WIDTH;
    if (image_width > MAX_WIDTH_V) eff_width = MAX_WIDTH_V;
    eff_height = (image_height < MIN_HEIGHT) ? MIN_HEIGHT : image_height;
  end

  assign last_col = eff_width - WIDTH_W'(1);
  assign last_row = eff_height - HEIGHT_W'(1);

  assign cur_col   = in_data.frame_start ? '0 : column_count;
  assign cur_row   = in_data.frame_start ? '0 : row_count;
  assign row_end   = ({1'b0, cur_col} >= last_col);
  assign frame_end = row_end && (cur_row >= last_row);

  always_comb begin
    column_count_next = cur_col + COL_W'(1);
    row_count_next    = cur_row;
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = (cur_row >= last_row) ? '0 : cur_row + HEIGHT_W'(1);
    end
  end

  assign rd_fire  = rd_valid && (!win_valid || win_ready);
  assign in_ready = !rd_valid || rd_fire;
  assign in_fire  = in_valid && in_ready;
  assign rd_top   = rd_fwd ? fwd_top : upper_rd;
  assign rd_mid   = rd_fwd ? fwd_mid : middle_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      rd_valid     <= 1'b0;
      win_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (in_fire)      rd_valid <= 1'b1;
      else if (rd_fire) rd_valid <= 1'b0;
      if (rd_fire)        win_valid <= 1'b1;
      else if (win_ready) win_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      upper_rd  <= upper_mem[cur_col];
      middle_rd <= middle_mem[cur_col];
    end
    if (rd_fire) begin
      upper_mem[rd_col]  <= rd_mid;
      middle_mem[rd_col] <= rd_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_col            <= cur_col;
      rd_pix            <= in_data.pixel_value;
      rd_ctl.emit       <= (cur_row >= HEIGHT_W'(2)) && (cur_col >= COL_W'(2));
      rd_ctl.frame_done <= frame_end;
      rd_fwd            <= rd_fire && (rd_col == cur_col);
      fwd_top           <= rd_mid;
      fwd_mid           <= rd_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (rd_fire) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= rd_top;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= rd_mid;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= rd_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) win_ctl <= rd_ctl;
  end

  riilbp_code u_code (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .win_ctl   (win_ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> src/riilbp_checker.sv
// Port-level checker for the rotation-invariant ILBP code block, with its bind
`default_nettype none

`include "rotation_invariant_ilbp_code_macros.svh"

module riilbp_checker import riilbp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input riilbp_out_t out_data
);

  `RIILBP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped before transfer")
  `RIILBP_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "output changed while stalled")
  `RIILBP_ASSERT_IMP(a_idle_ready, !out_valid, in_ready, "input stalled with empty output register")
  `RIILBP_ASSERT_RST(a_reset_clear, rst, in_ready && !out_valid, "pipeline not empty after reset")

endmodule

bind rotation_invariant_ilbp_code riilbp_checker u_riilbp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
